>>> rtl/sphp_pkg.sv
// Package: shared types and constants of the space packet header parser.
`default_nettype none
package sphp_pkg;

  // Largest payload byte count that a packet may announce.
  localparam int MAX_APP_DATA = 256;
  localparam int REM_W        = $clog2(MAX_APP_DATA + 1);

  localparam int LEN_W  = 16;
  localparam int HDR_W  = 48;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 16;

  // Header lengths in bytes, secondary header field positions, and the length field overhead for each form.
  localparam logic [POS_W-1:0] PRI_HDR_LEN = POS_W'(6);
  localparam logic [POS_W-1:0] SEC_HDR_LEN = POS_W'(9);
  localparam logic [POS_W-1:0] SEC_POS_FLAGS = POS_W'(6);
  localparam logic [POS_W-1:0] SEC_POS_TYPE  = POS_W'(7);
  localparam logic [LEN_W-1:0] OVER_SEC = LEN_W'(5);
  localparam logic [LEN_W-1:0] OVER_PRI = LEN_W'(2);

  // Result queue between the parser and the output stage.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PRIMARY   = 3'd0,
    KIND_SECONDARY = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_ERR_CTRL  = 3'd3,
    KIND_LEN_ERR   = 3'd4
  } kind_t;

  typedef struct packed {
    logic       ccsds;
    logic [2:0] pus;
    logic       ack;
  } sec_flags_t;

  localparam sec_flags_t SEC_DEFAULT = '{ccsds: 1'b0, pus: 3'd1, ack: 1'b0};

  // One result as the parser leaves it in the queue: raw header bytes,
  // decoded into fields by the output stage.
  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   value;
    logic [HDR_W-1:0]   hdr;
    sec_flags_t         sec;
  } rec_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/sphp_in_if.sv
// Interface: byte channel into the parser.
`default_nettype none
interface sphp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_packet;

  modport source (output valid, output data_byte, output first_of_packet, input ready);
  modport sink   (input valid, input data_byte, input first_of_packet, output ready);
endinterface
`default_nettype wire

>>> rtl/sphp_out_if.sv
// Interface: result channel out of the parser.
`default_nettype none
interface sphp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [2:0]  version;
  logic        has_secondary;
  logic [5:0]  source_id;
  logic [4:0]  dest_id;
  logic [1:0]  seq_flags;
  logic [13:0] seq_count;
  logic [15:0] length_field;
  logic [15:0] value_word;
  logic        ccsds_flag;
  logic [2:0]  pus_version;
  logic        ack_flag;

  modport source (output valid, output result_kind, output version, output has_secondary,
                  output source_id, output dest_id, output seq_flags, output seq_count,
                  output length_field, output value_word, output ccsds_flag,
                  output pus_version, output ack_flag, input ready);
  modport sink   (input valid, input result_kind, input version, input has_secondary,
                  input source_id, input dest_id, input seq_flags, input seq_count,
                  input length_field, input value_word, input ccsds_flag,
                  input pus_version, input ack_flag, output ready);
endinterface
`default_nettype wire

>>> rtl/sphp_front.sv
// Module: byte parser that tracks packet position and produces result records.
`default_nettype none
module sphp_front import sphp_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  sphp_in_if.sink    byte_chan,
  input  q_status_t  q_stat,
  output logic       push,
  output rec_t       rec
);

  logic [POS_W-1:0] pos, pos_next;
  logic [REM_W-1:0] remaining, remaining_next;
  logic [HDR_W-1:0] hdr, hdr_next;
  sec_flags_t       sec, sec_next;
  logic [7:0]       sec_type, sec_type_next;
  logic [7:0]       ec_high, ec_high_next;
  logic             discarding, discarding_next;

  logic accept;
  logic emit;

  assign byte_chan.ready = !q_stat.full;
  assign accept = byte_chan.valid && byte_chan.ready;
  assign push   = accept && emit;

  always_comb begin
    logic [POS_W-1:0] pos_e;
    logic [REM_W-1:0] rem_e;
    logic [HDR_W-1:0] hdr_e;
    sec_flags_t       sec_e;
    logic [7:0]       type_e;
    logic [7:0]       ech_e;
    logic             disc_e;
    logic [7:0]       b;
    logic [HDR_W-1:0] hdr_sh;
    logic [LEN_W-1:0] over;
    logic [LEN_W:0]   diff;
    logic [POS_W-1:0] hdr_len;

    b = byte_chan.data_byte;
    // A first byte restarts the packet before anything else happens.
    if (byte_chan.first_of_packet) begin
      pos_e  = '0;
      rem_e  = '0;
      hdr_e  = '0;
      sec_e  = SEC_DEFAULT;
      type_e = '0;
      ech_e  = '0;
      disc_e = 1'b0;
    end else begin
      pos_e  = pos;
      rem_e  = remaining;
      hdr_e  = hdr;
      sec_e  = sec;
      type_e = sec_type;
      ech_e  = ec_high;
      disc_e = discarding;
    end

    pos_next        = pos_e;
    remaining_next  = rem_e;
    hdr_next        = hdr_e;
    sec_next        = sec_e;
    sec_type_next   = type_e;
    ec_high_next    = ech_e;
    discarding_next = disc_e;
    emit            = 1'b0;
    rec.kind        = KIND_PRIMARY;
    rec.value       = '0;
    rec.hdr         = hdr_e;
    rec.sec         = sec_e;

    hdr_sh  = {hdr_e[HDR_W-9:0], b};
    over    = hdr_sh[43] ? OVER_SEC : OVER_PRI;
    diff    = {1'b0, hdr_sh[LEN_W-1:0]} - {1'b0, over};
    hdr_len = hdr_e[43] ? SEC_HDR_LEN : PRI_HDR_LEN;

    if (!disc_e) begin
      if (pos_e < PRI_HDR_LEN) begin
        hdr_next = hdr_sh;
        pos_next = pos_e + POS_W'(1);
        rec.hdr  = hdr_sh;
        if (pos_e == PRI_HDR_LEN - POS_W'(1)) begin
          emit = 1'b1;
          if (diff[LEN_W] || (diff[LEN_W-1:0] > LEN_W'(MAX_APP_DATA))) begin
            discarding_next = 1'b1;
            rec.kind        = KIND_LEN_ERR;
          end else begin
            remaining_next = diff[REM_W-1:0];
            rec.kind       = KIND_PRIMARY;
          end
        end
      end else if (pos_e < hdr_len) begin
        pos_next = pos_e + POS_W'(1);
        if (pos_e == SEC_POS_FLAGS) begin
          sec_next.ccsds = b[7];
          sec_next.pus   = b[6:4];
          sec_next.ack   = (b[3:0] == 4'd1);
        end else if (pos_e == SEC_POS_TYPE) begin
          sec_type_next = b;
        end else begin
          emit      = 1'b1;
          rec.kind  = KIND_SECONDARY;
          rec.value = {type_e, b};
        end
      end else if (rem_e != '0) begin
        remaining_next = rem_e - REM_W'(1);
        emit           = 1'b1;
        rec.kind       = KIND_PAYLOAD;
        rec.value      = {8'h00, b};
      end else if (pos_e == hdr_len) begin
        ec_high_next = b;
        pos_next     = pos_e + POS_W'(1);
      end else begin
        discarding_next = 1'b1;
        emit            = 1'b1;
        rec.kind        = KIND_ERR_CTRL;
        rec.value       = {ech_e, b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      remaining  <= '0;
      hdr        <= '0;
      sec        <= '0;
      sec_type   <= '0;
      ec_high    <= '0;
      discarding <= 1'b1;
    end else if (accept) begin
      pos        <= pos_next;
      remaining  <= remaining_next;
      hdr        <= hdr_next;
      sec        <= sec_next;
      sec_type   <= sec_type_next;
      ec_high    <= ec_high_next;
      discarding <= discarding_next;
    end
  end

  // Closing results leave the parser dropping input.
  a_done_drops: assert property (@(posedge clk) disable iff (rst)
    push && (rec.kind == KIND_ERR_CTRL || rec.kind == KIND_LEN_ERR) |=> discarding)
    else $error("parser not dropping after packet end");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= REM_W'(MAX_APP_DATA))
    else $error("payload count above limit");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= SEC_HDR_LEN + POS_W'(1))
    else $error("byte position out of range");

endmodule
`default_nettype wire

>>> rtl/sphp_queue.sv
// Module: short result queue between parser and output stage.
`default_nettype none
module sphp_queue import sphp_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  logic       push,
  input  rec_t       wr_rec,
  input  logic       pop,
  output rec_t       rd_rec,
  output q_status_t  q_stat
);

  rec_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QCW-1:0]   count;

  assign q_stat.full  = (count == QCW'(QDEPTH));
  assign q_stat.valid = (count != '0);
  assign rd_rec       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_stat.valid))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> rtl/sphp_back.sv
// Module: output stage that decodes header fields into the result register.
`default_nettype none
module sphp_back import sphp_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  q_status_t  q_stat,
  input  rec_t       rd_rec,
  output logic       pop,
  sphp_out_if.source result_chan
);

  logic out_valid;

  assign pop = q_stat.valid && (!out_valid || result_chan.ready);
  assign result_chan.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result_chan.ready) begin
      out_valid <= q_stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_chan.result_kind   <= rd_rec.kind;
      result_chan.version       <= rd_rec.hdr[47:45];
      result_chan.has_secondary <= rd_rec.hdr[43];
      result_chan.source_id     <= {rd_rec.hdr[42:40], rd_rec.hdr[39:37]};
      result_chan.dest_id       <= rd_rec.hdr[36:32];
      result_chan.seq_flags     <= rd_rec.hdr[31:30];
      result_chan.seq_count     <= rd_rec.hdr[29:16];
      result_chan.length_field  <= rd_rec.hdr[15:0];
      result_chan.value_word    <= rd_rec.value;
      result_chan.ccsds_flag    <= rd_rec.sec.ccsds;
      result_chan.pus_version   <= rd_rec.sec.pus;
      result_chan.ack_flag      <= rd_rec.sec.ack;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("loaded result not presented");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_chan.ready |-> !pop)
    else $error("result overwritten while stalled");

  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid && q_stat.valid |-> pop)
    else $error("empty output stage not refilled");

endmodule
`default_nettype wire

>>> rtl/space_packet_header_parser_top.sv
// Top level: space packet header parser with decoupled parser and output stage.
`default_nettype none
// Space packet header parser. Bytes of a packet enter on byte_chan, one beat
// per byte, with first_of_packet set on byte 0; every such byte restarts the
// parser and abandons any packet in progress. Bytes before the first flagged
// byte, and bytes after a packet's error control word or a length error, are
// dropped without a result. The block takes one byte per clock cycle and
// gives at most one result beat per byte. Results pass through a four-entry
// queue and a registered output stage, so a result is written into the queue
// and then loaded into the output register before it shows on result_chan.
// The byte side keeps taking one byte a cycle while the result side stalls,
// until the queue holds four results; it then lowers ready until the output
// stage takes a beat and frees a queue entry. Every result beat carries the
// decoded primary header fields of its packet and the current secondary
// header flags (defaults until decoded). The payload limit is MAX_APP_DATA
// bytes, set in the package.
module space_packet_header_parser_top import sphp_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  sphp_in_if.sink    byte_chan,
  sphp_out_if.source result_chan
);

  logic      push;
  logic      pop;
  rec_t      wr_rec;
  rec_t      rd_rec;
  q_status_t q_stat;

  // Front: take bytes, track position, build result records.
  sphp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .q_stat    (q_stat),
    .push      (push),
    .rec       (wr_rec)
  );

  // Queue: hold records so each side can stall on its own.
  sphp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .q_stat (q_stat)
  );

  // Back: decode header fields and present each result beat.
  sphp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .rd_rec      (rd_rec),
    .pop         (pop),
    .result_chan (result_chan)
  );

endmodule
`default_nettype wire
